@@ rtl/core/ptd_pkg.sv @@
`default_nettype none
package ptd_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_CREATE  = 3'd1;
  localparam logic [2:0] REQ_SUSPEND = 3'd2;
  localparam logic [2:0] REQ_RESUME  = 3'd3;
  localparam logic [2:0] REQ_DELETE  = 3'd4;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NULL    = 2'd1;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_CREATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        occupied;
    logic        ready;
    logic [15:0] period;
    logic [15:0] countdown;
  } slot_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    slot_entry_t       entry;
  } slot_wr_t;

endpackage
`default_nettype wire

@@ rtl/core/ptd_slot_table.sv @@
`default_nettype none
module ptd_slot_table (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [ptd_pkg::SLOT_W-1:0] rd_idx,
  output ptd_pkg::slot_entry_t           rd_entry,
  input  wire ptd_pkg::slot_wr_t         wr
);

  ptd_pkg::slot_entry_t tbl_r [ptd_pkg::TASK_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptd_pkg::TASK_SLOTS; i++) begin
        tbl_r[i] <= '0;
      end
    end else if (wr.en) begin
      tbl_r[wr.idx] <= wr.entry;
    end
  end

  assign rd_entry = tbl_r[rd_idx];

endmodule
`default_nettype wire

@@ rtl/core/periodic_task_dispatcher.sv @@
`default_nettype none
// Periodic task dispatcher: a table of task slots serviced one request at a
// time. A tick walks every slot through one shared 16-bit decrement and zero
// check, one slot per cycle while no firing waits on a stalled output word,
// with in_stall high from the accept until the final word is pushed.
// A create searches upward from the requested slot, one slot per cycle, up
// to the last slot; suspend, resume, delete and unknown requests go straight
// to completion. Any request takes longer while out_stall holds back one of
// its output words. Each fired slot of a tick is one output word in slot
// order, the final word of every request carries out_last, and a tick with
// nothing due gives one word with out_fired clear. The slot table is cleared
// by reset, with no clearing pass.
module periodic_task_dispatcher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [2:0]  in_task_slot,
  input  wire logic [15:0] in_period,
  input  wire logic [15:0] in_first_delay,
  input  wire logic        in_start_ready,
  input  wire logic        in_handler_present,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_fired,
  output logic [2:0]       out_task_index,
  output logic [1:0]       out_status,
  output logic             out_last
);

  localparam logic [ptd_pkg::SLOT_W-1:0] LAST_SLOT =
    ptd_pkg::SLOT_W'(ptd_pkg::TASK_SLOTS - 1);

  ptd_pkg::state_t state_r, state_nxt;
  logic [ptd_pkg::SLOT_W-1:0] idx_r, idx_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [2:0]  pend_idx_r, pend_idx_nxt;
  logic        fin_fired_r, fin_fired_nxt;
  logic [2:0]  fin_idx_r, fin_idx_nxt;
  logic [1:0]  fin_status_r, fin_status_nxt;
  logic [2:0]  slot_r, slot_nxt;
  logic [15:0] period_r, period_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic        ready_r, ready_nxt;

  logic        out_valid_r;
  logic        out_fired_r;
  logic [2:0]  out_task_index_r;
  logic [1:0]  out_status_r;
  logic        out_last_r;

  logic        push;
  logic        push_fired;
  logic [2:0]  push_idx;
  logic [1:0]  push_status;
  logic        push_last;

  logic        in_accept;
  logic        out_free;
  logic        slot_in_range;
  logic        active;
  logic        due;
  logic [15:0] dec_opnd;
  logic [15:0] dec_res;

  logic [ptd_pkg::SLOT_W-1:0] rd_idx;
  ptd_pkg::slot_entry_t       rd_entry;
  ptd_pkg::slot_wr_t          wr;

  ptd_slot_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  assign in_stall      = (state_r != ptd_pkg::ST_IDLE);
  assign in_accept     = in_valid && !in_stall;
  assign out_free      = !out_valid_r || !out_stall;
  assign slot_in_range = (32'(in_task_slot) < ptd_pkg::TASK_SLOTS);
  assign rd_idx        = (state_r == ptd_pkg::ST_IDLE) ?
                         ptd_pkg::SLOT_W'(in_task_slot) : idx_r;

  // Shared decrement: reload from period on a due slot, else count down.
  assign active   = rd_entry.occupied && rd_entry.ready;
  assign due      = (rd_entry.countdown == 16'd0);
  assign dec_opnd = due ? rd_entry.period : rd_entry.countdown;
  assign dec_res  = dec_opnd - 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptd_pkg::ST_IDLE;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    fin_fired_r  <= fin_fired_nxt;
    fin_idx_r    <= fin_idx_nxt;
    fin_status_r <= fin_status_nxt;
    slot_r       <= slot_nxt;
    period_r     <= period_nxt;
    delay_r      <= delay_nxt;
    ready_r      <= ready_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    fin_fired_nxt  = fin_fired_r;
    fin_idx_nxt    = fin_idx_r;
    fin_status_nxt = fin_status_r;
    slot_nxt       = slot_r;
    period_nxt     = period_r;
    delay_nxt      = delay_r;
    ready_nxt      = ready_r;
    wr             = '0;
    push           = 1'b0;
    push_fired     = 1'b0;
    push_idx       = 3'd0;
    push_status    = ptd_pkg::STATUS_OK;
    push_last      = 1'b0;

    case (state_r)
      ptd_pkg::ST_IDLE: begin
        if (in_accept) begin
          slot_nxt       = in_task_slot;
          period_nxt     = in_period;
          delay_nxt      = in_first_delay;
          ready_nxt      = in_start_ready;
          fin_fired_nxt  = 1'b0;
          fin_idx_nxt    = in_task_slot;
          fin_status_nxt = ptd_pkg::STATUS_OK;
          state_nxt      = ptd_pkg::ST_DONE;
          case (in_req_type)
            ptd_pkg::REQ_TICK: begin
              idx_nxt        = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = ptd_pkg::ST_TICK;
            end
            ptd_pkg::REQ_CREATE: begin
              if (!in_handler_present) begin
                fin_status_nxt = ptd_pkg::STATUS_NULL;
              end else if (!slot_in_range) begin
                fin_status_nxt = ptd_pkg::STATUS_NO_SLOT;
              end else begin
                idx_nxt   = ptd_pkg::SLOT_W'(in_task_slot);
                state_nxt = ptd_pkg::ST_CREATE;
              end
            end
            ptd_pkg::REQ_SUSPEND, ptd_pkg::REQ_RESUME: begin
              wr.en          = slot_in_range;
              wr.idx         = ptd_pkg::SLOT_W'(in_task_slot);
              wr.entry       = rd_entry;
              wr.entry.ready = (in_req_type == ptd_pkg::REQ_RESUME);
            end
            ptd_pkg::REQ_DELETE: begin
              wr.en    = slot_in_range;
              wr.idx   = ptd_pkg::SLOT_W'(in_task_slot);
              wr.entry = '0;
            end
            default: begin
              fin_idx_nxt = 3'd0;
            end
          endcase
        end
      end

      ptd_pkg::ST_TICK: begin
        // Hold the walk when a second firing finds the output word still taken.
        if (!(active && due && pend_valid_r && !out_free)) begin
          wr.en              = active;
          wr.idx             = idx_r;
          wr.entry           = rd_entry;
          wr.entry.countdown = dec_res;
          if (active && due) begin
            push           = pend_valid_r;
            push_fired     = 1'b1;
            push_idx       = pend_idx_r;
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = 3'(idx_r);
          end
          if (idx_r == LAST_SLOT) begin
            fin_fired_nxt  = pend_valid_nxt;
            fin_idx_nxt    = pend_valid_nxt ? pend_idx_nxt : 3'd0;
            fin_status_nxt = ptd_pkg::STATUS_OK;
            pend_valid_nxt = 1'b0;
            state_nxt      = ptd_pkg::ST_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ptd_pkg::ST_CREATE: begin
        if (!rd_entry.occupied) begin
          wr.en                = 1'b1;
          wr.idx               = idx_r;
          wr.entry.occupied    = 1'b1;
          wr.entry.ready       = ready_r;
          wr.entry.period      = period_r;
          wr.entry.countdown   = delay_r;
          fin_idx_nxt          = 3'(idx_r);
          fin_status_nxt       = ptd_pkg::STATUS_OK;
          state_nxt            = ptd_pkg::ST_DONE;
        end else if (idx_r == LAST_SLOT) begin
          fin_idx_nxt    = slot_r;
          fin_status_nxt = ptd_pkg::STATUS_NO_SLOT;
          state_nxt      = ptd_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ptd_pkg::ST_DONE: begin
        if (out_free) begin
          push        = 1'b1;
          push_fired  = fin_fired_r;
          push_idx    = fin_idx_r;
          push_status = fin_status_r;
          push_last   = 1'b1;
          state_nxt   = ptd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ptd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_fired_r      <= push_fired;
      out_task_index_r <= push_idx;
      out_status_r     <= push_status;
      out_last_r       <= push_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fired      = out_fired_r;
  assign out_task_index = out_task_index_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("output word overwritten while stalled");

  a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == ptd_pkg::ST_TICK))
    else $error("pending firing outside a tick walk");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fired_r) |-> (out_status_r == ptd_pkg::STATUS_OK))
    else $error("fired word with error status");

  a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_req_type != ptd_pkg::REQ_TICK &&
     in_req_type != ptd_pkg::REQ_CREATE) |=> (state_r == ptd_pkg::ST_DONE))
    else $error("table request did not go straight to completion");

endmodule
`default_nettype wire
